// ===== sv/pff_pkg.sv =====
// pareto front filter: shared widths, register indexes and the
// controller/datapath command and status structs (no dependencies)
package pff_pkg;

  localparam int NOBJ       = 4;
  localparam int OBJ_W      = 32;
  localparam int IDX_W      = 6;
  localparam int CFG_W      = 4;
  localparam int CFG_ADDR_W = 1;

  localparam logic [CFG_ADDR_W-1:0] CFG_USE_MASK = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_MASK = 1'b1;

  typedef logic [NOBJ-1:0][OBJ_W-1:0] point_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // latch the accepted item
    logic ovf_set;     // item dropped, store is full
    logic scan_start;  // clear scan counters and the dominated mark
    logic scan_step;   // at most one read issued, at most one compare retired
    logic store;       // write the new point and its front flag
    logic emit_load;   // load one result into the output register
  } pff_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic full;
    logic final_pt;
    logic slot_free;
    logic emit_last;
  } pff_stat_t;

endpackage

// ===== sv/pff_in_if.sv =====
// pareto front filter: input channel, one point per item
// depends on pff_pkg
interface pff_in_if import pff_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OBJ_W-1:0] obj_0;
  logic [OBJ_W-1:0] obj_1;
  logic [OBJ_W-1:0] obj_2;
  logic [OBJ_W-1:0] obj_3;
  logic             final_point;

  modport source (output valid, obj_0, obj_1, obj_2, obj_3, final_point, input ready);
  modport sink   (input valid, obj_0, obj_1, obj_2, obj_3, final_point, output ready);
endinterface

// ===== sv/pff_out_if.sv =====
// pareto front filter: result channel, one stored point per item
// depends on pff_pkg
interface pff_out_if import pff_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] point_index;
  logic             on_front;
  logic             overflowed;
  logic             run_end;

  modport source (output valid, point_index, on_front, overflowed, run_end, input ready);
  modport sink   (input valid, point_index, on_front, overflowed, run_end, output ready);
endinterface

// ===== sv/pff_ctrl.sv =====
// pareto front filter: sequencing state machine
// depends on pff_pkg
module pff_ctrl import pff_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_final,
  output logic      in_ready,
  input  pff_stat_t stat,
  output pff_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_STORE,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.full) begin
            cmd.ovf_set = 1'b1;
            if (in_final) state_nxt = S_EMIT;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_done) state_nxt = S_STORE;
        else cmd.scan_step = 1'b1;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_nxt = stat.final_pt ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit_load = 1'b1;
          if (stat.emit_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/pff_dp.sv =====
// pareto front filter: point memory, front flags, compare unit, output register
// depends on pff_pkg
module pff_dp import pff_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int DIMS     = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  point_t                in_point,
  input  logic                  in_final,
  input  pff_cmd_t              cmd,
  output pff_stat_t             stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [IDX_W-1:0]      out_point_index,
  output logic                  out_on_front,
  output logic                  out_overflowed,
  output logic                  out_run_end
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CFG_W-1:0]    use_mask_r, max_mask_r;
  point_t              pt_r;
  logic                final_r;
  point_t              mem [CAPACITY];
  point_t              mem_q_r;
  logic [CAPACITY-1:0] flags_r;
  logic [CW-1:0]       count_r;
  logic                ovf_r;
  logic [CW-1:0]       rd_cnt_r;
  logic                rd_vld_r;
  logic [IW-1:0]       cmp_idx_r;
  logic                dominated_r;
  logic [IW-1:0]       emit_cnt_r;
  logic                out_vld_r;
  logic                issue;
  logic                any_better, any_worse;
  logic                cmp_live;

  // dominance of the new point against the entry just read
  always_comb begin
    any_better = 1'b0;
    any_worse  = 1'b0;
    for (int d = 0; d < NOBJ; d++) begin
      if (use_mask_r[d] && (d < DIMS) && (pt_r[d] != mem_q_r[d])) begin
        if (($signed(pt_r[d]) > $signed(mem_q_r[d])) == max_mask_r[d]) any_better = 1'b1;
        else any_worse = 1'b1;
      end
    end
  end

  assign issue    = cmd.scan_step && (rd_cnt_r != count_r);
  assign cmp_live = cmd.scan_step && rd_vld_r && !dominated_r && flags_r[cmp_idx_r];

  assign stat.scan_done = dominated_r || ((rd_cnt_r == count_r) && !rd_vld_r);
  assign stat.full      = (count_r == CW'(CAPACITY));
  assign stat.final_pt  = final_r;
  assign stat.slot_free = !out_vld_r || out_ready;
  assign stat.emit_last = ((CW'(emit_cnt_r) + CW'(1)) == count_r);

  assign out_valid = out_vld_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_mask_r <= '1;
      max_mask_r <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_USE_MASK: use_mask_r <= cfg_wdata;
        CFG_MAX_MASK: max_mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // point memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.store) mem[count_r[IW-1:0]] <= pt_r;
    if (issue) mem_q_r <= mem[rd_cnt_r[IW-1:0]];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pt_r    <= in_point;
      final_r <= in_final;
    end
    if (issue) cmp_idx_r <= rd_cnt_r[IW-1:0];
    if (cmd.emit_load) begin
      out_point_index <= IDX_W'(emit_cnt_r);
      out_on_front    <= flags_r[emit_cnt_r];
      out_overflowed  <= ovf_r;
      out_run_end     <= stat.emit_last;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      rd_cnt_r    <= '0;
      rd_vld_r    <= 1'b0;
      dominated_r <= 1'b0;
      emit_cnt_r  <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cmd.ovf_set) ovf_r <= 1'b1;
      if (cmd.scan_start) begin
        rd_cnt_r    <= '0;
        rd_vld_r    <= 1'b0;
        dominated_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        rd_vld_r <= issue;
        if (issue) rd_cnt_r <= rd_cnt_r + CW'(1);
        if (cmp_live && any_better && !any_worse) flags_r[cmp_idx_r] <= 1'b0;
        if (cmp_live && any_worse && !any_better) dominated_r <= 1'b1;
      end
      if (cmd.store) begin
        flags_r[count_r[IW-1:0]] <= !dominated_r;
        count_r                  <= count_r + CW'(1);
      end
      if (cmd.emit_load) begin
        out_vld_r <= 1'b1;
        if (stat.emit_last) begin
          emit_cnt_r <= '0;
          count_r    <= '0;
          ovf_r      <= 1'b0;
          flags_r    <= '0;
        end else begin
          emit_cnt_r <= emit_cnt_r + IW'(1);
        end
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/pareto_front_filter_top.sv =====
// pareto front filter: top level, joins the controller and the datapath
// depends on pff_pkg, pff_in_if, pff_out_if, pff_ctrl, pff_dp
//  - in_chan carries one point per item: four signed q16.16 objectives and
//    final_point; out_chan carries one result per stored point of the set
//  - cfg_we/cfg_index/cfg_wdata write use_mask (index 0) and max_mask
//    (index 1); write them only while the block is idle
//  - an item is taken only when the block is idle; it then scans the stored
//    points one memory read per cycle, ending early when an earlier point
//    dominates it; the scan length is set by the number of stored points
//    and the single read port
//  - an item marked final_point then emits one result per stored point, one
//    per cycle while out_chan.ready is high, from the emit state through the
//    output register; run_end marks the last one, then the set restarts
//  - an item arriving when CAPACITY points are stored is dropped and flags
//    overflowed on every result of the run
//  - results sit in an output register: a stalled receiver holds the run,
//    while the next item may already be taken once the last result is loaded
//  - reset (rst_n low, synchronous) restores both masks to all ones and
//    empties the set; no clearing pass is needed
module pareto_front_filter_top import pff_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int DIMS     = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pff_in_if.sink                in_chan,
  pff_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  pff_cmd_t  cmd;
  pff_stat_t stat;
  point_t    in_point;
  logic      in_rdy;

  // objectives packed in dimension order
  assign in_point      = {in_chan.obj_3, in_chan.obj_2, in_chan.obj_1, in_chan.obj_0};
  assign in_chan.ready = in_rdy;

  // sequencing: idle / scan / store / emit
  pff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_final (in_chan.final_point),
    .in_ready (in_rdy),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage, compare unit and result register
  pff_dp #(
    .CAPACITY (CAPACITY),
    .DIMS     (DIMS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_point        (in_point),
    .in_final        (in_chan.final_point),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_point_index (out_chan.point_index),
    .out_on_front    (out_chan.on_front),
    .out_overflowed  (out_chan.overflowed),
    .out_run_end     (out_chan.run_end)
  );

endmodule
